// ===== hdl/teta_pkg.sv =====
// ----------------------------------------------------------------------------
// teta_pkg: shared types and constants for track eta at trigger planes
// Plane radii, fixed-point constants and the payloads of the cell chains.
// ----------------------------------------------------------------------------
package teta_pkg;

	localparam int DIV_STEPS  = 31;
	localparam int SQRT_STEPS = 32;
	localparam int LOG_STEPS  = 16;
	// prep 3, divide, square 1, root, add 1, normalize 1, log, product 1, final 1
	localparam int PLANE_LAT  = 3 + DIV_STEPS + 1 + SQRT_STEPS + 2 + LOG_STEPS + 2;

	localparam logic [10:0] SAT_LIMIT   = 11'd1491;
	localparam logic [31:0] LN2_Q32     = 32'hB172_17F8;
	localparam logic [15:0] ETA_MAX_POS = 16'h7FFF;
	localparam logic [15:0] ETA_MIN_NEG = 16'h8000;
	localparam logic [16:0] MAG_SAT     = 17'd32768;

	typedef enum logic [1:0] {
		PLANE_INNER  = 2'd0,
		PLANE_MIDDLE = 2'd1,
		PLANE_OUTER  = 2'd2
	} plane_t;

	typedef struct packed {
		logic ok;
		logic neg;
		logic sat;
	} flags_t;

	typedef struct packed {
		flags_t      f;
		logic [44:0] den;
		logic [44:0] rem;
		logic [30:0] bits;
		logic [30:0] quot;
	} div_st_t;

	typedef struct packed {
		flags_t      f;
		logic [30:0] a;
		logic [63:0] v;
		logic [63:0] res;
	} sqrt_st_t;

	typedef struct packed {
		flags_t      f;
		logic [30:0] m;
		logic [19:0] lg;
	} log_st_t;

	typedef struct packed {
		logic        last;
		logic        ok_o;
		logic        ok_m;
		logic        ok_i;
		logic [15:0] eta_o;
		logic [15:0] eta_m;
		logic [15:0] eta_i;
	} result_t;

	// plane radius in mm for a sector kind
	function automatic logic [13:0] radius(input logic [1:0] sector, input plane_t plane);
		logic [13:0] r;
		r = 14'd0;
		case (sector)
			2'd0: begin
				case (plane)
					PLANE_INNER:  r = 14'd6800;
					PLANE_MIDDLE: r = 14'd7478;
					PLANE_OUTER:  r = 14'd9832;
					default:      r = 14'd0;
				endcase
			end
			2'd1: begin
				case (plane)
					PLANE_INNER:  r = 14'd7820;
					PLANE_MIDDLE: r = 14'd8365;
					PLANE_OUTER:  r = 14'd10229;
					default:      r = 14'd0;
				endcase
			end
			2'd2: begin
				case (plane)
					PLANE_INNER:  r = 14'd7740;
					PLANE_MIDDLE: r = 14'd8100;
					PLANE_OUTER:  r = 14'd11000;
					default:      r = 14'd0;
				endcase
			end
			default: begin
				case (plane)
					PLANE_INNER:  r = 14'd7850;
					PLANE_MIDDLE: r = 14'd8400;
					PLANE_OUTER:  r = 14'd10400;
					default:      r = 14'd0;
				endcase
			end
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/teta_div_cell.sv =====
// ----------------------------------------------------------------------------
// teta_div_cell: one restoring division step
// Shift in the next dividend bit, subtract the divisor when it fits.
// ----------------------------------------------------------------------------
module teta_div_cell (
	input  logic              clk,
	input  logic              en,
	input  teta_pkg::div_st_t d,
	output teta_pkg::div_st_t q
);

	logic [45:0]       trial;
	logic              fits;
	teta_pkg::div_st_t nxt;

	always_comb begin
		trial    = {d.rem, d.bits[30]};
		fits     = trial >= {1'b0, d.den};
		nxt      = d;
		nxt.rem  = fits ? 45'(trial - {1'b0, d.den}) : trial[44:0];
		nxt.bits = {d.bits[29:0], 1'b0};
		nxt.quot = {d.quot[29:0], fits};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// ===== hdl/teta_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// teta_sqrt_cell: one digit of the integer square root
// Try the current bit against the remainder, update root and remainder.
// ----------------------------------------------------------------------------
module teta_sqrt_cell #(
	parameter int BIT_POS = 62
) (
	input  logic               clk,
	input  logic               en,
	input  teta_pkg::sqrt_st_t d,
	output teta_pkg::sqrt_st_t q
);

	localparam logic [63:0] BitVal = 64'd1 << BIT_POS;

	logic [63:0]        trial;
	teta_pkg::sqrt_st_t nxt;

	always_comb begin
		trial = d.res + BitVal;
		nxt   = d;
		if (d.v >= trial) begin
			nxt.v   = d.v - trial;
			nxt.res = (d.res >> 1) + BitVal;
		end else begin
			nxt.res = d.res >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// ===== hdl/teta_log_cell.sv =====
// ----------------------------------------------------------------------------
// teta_log_cell: one fraction bit of log2 by squaring
// Square the Q1.30 mantissa, emit a bit and renormalize when it reaches two.
// ----------------------------------------------------------------------------
module teta_log_cell (
	input  logic              clk,
	input  logic              en,
	input  teta_pkg::log_st_t d,
	output teta_pkg::log_st_t q
);

	logic [61:0]       sq;
	logic [31:0]       sq_hi;
	teta_pkg::log_st_t nxt;

	always_comb begin
		sq     = d.m * d.m;
		sq_hi  = sq[61:30];
		nxt    = d;
		nxt.lg = {d.lg[18:0], sq_hi[31]};
		nxt.m  = sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// ===== hdl/teta_plane.sv =====
// ----------------------------------------------------------------------------
// teta_plane: eta pipeline for one plane
// Ratio by a divide chain, asinh via root and log chains, then round and clamp.
// ----------------------------------------------------------------------------
module teta_plane (
	input  logic               clk,
	input  logic               en,
	input  logic [13:0]        r,
	input  logic               ok_in,
	input  logic signed [31:0] slope,
	input  logic signed [23:0] offset,
	output logic [15:0]        eta,
	output logic               ok
);

	// numerator and denominator
	logic signed [25:0] n_c;
	logic signed [46:0] d_c;
	logic signed [25:0] n_s1;
	logic signed [46:0] d_s1;
	logic               ok_s1;

	assign n_c = $signed({8'b0, r, 4'b0}) - {{2{offset[23]}}, offset};
	assign d_c = slope * $signed({1'b0, r});

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1  <= n_c;
			d_s1  <= d_c;
			ok_s1 <= ok_in;
		end
	end

	// magnitudes, sign and overflow bound
	logic [25:0] absn_c;
	logic [46:0] absd_c;
	logic [36:0] num_s2;
	logic [44:0] den_s2;
	logic [55:0] denx_s2;
	logic        neg_s2;
	logic        ok_s2;

	assign absn_c = n_s1[25] ? 26'(-n_s1) : 26'(n_s1);
	assign absd_c = d_s1[46] ? 47'(-d_s1) : 47'(d_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2  <= {absn_c[24:0], 12'b0};
			den_s2  <= absd_c[44:0];
			denx_s2 <= {11'b0, absd_c[44:0]} * {45'b0, teta_pkg::SAT_LIMIT};
			neg_s2  <= n_s1[25] ^ d_s1[46];
			ok_s2   <= ok_s1;
		end
	end

	// load the divide chain
	teta_pkg::div_st_t dv [0:teta_pkg::DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			dv[0].f.ok  <= ok_s2;
			dv[0].f.neg <= neg_s2;
			dv[0].f.sat <= {19'b0, num_s2} >= denx_s2;
			dv[0].den   <= den_s2;
			dv[0].rem   <= {19'b0, num_s2[36:11]};
			dv[0].bits  <= {num_s2[10:0], 20'b0};
			dv[0].quot  <= '0;
		end
	end

	for (genvar k = 0; k < teta_pkg::DIV_STEPS; k++) begin : g_div
		teta_div_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (dv[k]),
			.q   (dv[k+1])
		);
	end

	// a*a + 1 in Q.40
	teta_pkg::sqrt_st_t sq [0:teta_pkg::SQRT_STEPS];
	logic [61:0] asq_c;

	assign asq_c = dv[teta_pkg::DIV_STEPS].quot * dv[teta_pkg::DIV_STEPS].quot;

	always_ff @(posedge clk) begin
		if (en) begin
			sq[0].f   <= dv[teta_pkg::DIV_STEPS].f;
			sq[0].a   <= dv[teta_pkg::DIV_STEPS].quot;
			sq[0].v   <= {2'b0, asq_c} + (64'd1 << 40);
			sq[0].res <= '0;
		end
	end

	for (genvar k = 0; k < teta_pkg::SQRT_STEPS; k++) begin : g_sqrt
		teta_sqrt_cell #(
			.BIT_POS (62 - 2 * k)
		) u_cell (
			.clk (clk),
			.en  (en),
			.d   (sq[k]),
			.q   (sq[k+1])
		);
	end

	// y = a + sqrt(a*a + 1)
	logic [32:0]       y_s;
	teta_pkg::flags_t  fy_s;

	always_ff @(posedge clk) begin
		if (en) begin
			y_s  <= {2'b0, sq[teta_pkg::SQRT_STEPS].a} + sq[teta_pkg::SQRT_STEPS].res[32:0];
			fy_s <= sq[teta_pkg::SQRT_STEPS].f;
		end
	end

	// normalize: leading one to bit 30, exponent from bit 20
	logic [5:0]  pos_c;
	logic [30:0] mant_c;
	teta_pkg::log_st_t lgc [0:teta_pkg::LOG_STEPS];

	always_comb begin
		pos_c = 6'd20;
		for (int i = 20; i <= 32; i++) begin
			if (y_s[i]) begin
				pos_c = 6'(i);
			end
		end
		if (pos_c <= 6'd30) begin
			mant_c = 31'(y_s << (6'd30 - pos_c));
		end else begin
			mant_c = 31'(y_s >> (pos_c - 6'd30));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lgc[0].f  <= fy_s;
			lgc[0].m  <= mant_c;
			lgc[0].lg <= {16'b0, 4'(pos_c - 6'd20)};
		end
	end

	for (genvar k = 0; k < teta_pkg::LOG_STEPS; k++) begin : g_log
		teta_log_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (lgc[k]),
			.q   (lgc[k+1])
		);
	end

	// scale log2 by ln2
	logic [51:0]      prod_s;
	teta_pkg::flags_t fp_s;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s <= {32'b0, lgc[teta_pkg::LOG_STEPS].lg} * {20'b0, teta_pkg::LN2_Q32};
			fp_s   <= lgc[teta_pkg::LOG_STEPS].f;
		end
	end

	// round, clamp, apply sign
	logic [52:0] rnd_c;
	logic [16:0] mag_c;
	logic [15:0] eta_c;

	always_comb begin
		rnd_c = {1'b0, prod_s} + (53'd1 << 35);
		mag_c = fp_s.sat ? teta_pkg::MAG_SAT : rnd_c[52:36];
		if (!fp_s.ok) begin
			eta_c = '0;
		end else if (fp_s.neg) begin
			eta_c = (mag_c > teta_pkg::MAG_SAT) ? teta_pkg::ETA_MIN_NEG : 16'(-mag_c);
		end else begin
			eta_c = (mag_c > {1'b0, teta_pkg::ETA_MAX_POS}) ? teta_pkg::ETA_MAX_POS
				: mag_c[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eta <= eta_c;
			ok  <= fp_s.ok;
		end
	end

endmodule

// ===== hdl/track_eta_at_rpc_planes_unit.sv =====
// ----------------------------------------------------------------------------
// track_eta_at_rpc_planes_unit: muon track eta at three trigger planes
// Per candidate, look up plane radii by sector and give asinh of the track
// ratio at the inner, middle and outer plane in signed Q4.12.
// ----------------------------------------------------------------------------
//
// channel | dir | tdata                                   | tuser    | tlast
// s_      | in  | sector, mid_slope, mid_offset,          | -        | last_muon
//         |     | out_slope, out_offset                   |          |
// m_      | out | inner_eta, middle_eta, outer_eta        | ok flags | event_end
//
// One candidate enters per cycle while the output buffer has room; its result
// passes through the 31-cell divide chain, the 32-cell square root chain and
// the 16-cell log chain of each plane, all three planes running side by side.
// Reset clears the stage valid bits and the output buffer count only.
// A two-entry output buffer takes results while m_tready is low; the whole
// pipeline holds only when both entries are full, so s_tready depends on the buffer count alone.
//
module track_eta_at_rpc_planes_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// sector[3:0], mid_slope[35:4], mid_offset[59:36], out_slope[91:60],
	// out_offset[115:92], zero fill [119:116]
	input  logic [119:0] s_tdata,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// inner_eta[15:0], middle_eta[31:16], outer_eta[47:32]
	output logic [47:0]  m_tdata,
	// inner_ok[0], middle_ok[1], outer_ok[2]
	output logic [2:0]   m_tuser,
	output logic         m_tlast
);

	localparam int Lat = teta_pkg::PLANE_LAT;

	// advance the whole pipeline while the output buffer has room
	logic [1:0] cnt_q;
	logic       en;

	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;

	// unpack the incoming transfer
	logic [3:0]         sector;
	logic signed [31:0] mid_slope;
	logic signed [23:0] mid_offset;
	logic signed [31:0] out_slope;
	logic signed [23:0] out_offset;
	logic               sec_ok;

	assign sector     = s_tdata[3:0];
	assign mid_slope  = s_tdata[35:4];
	assign mid_offset = s_tdata[59:36];
	assign out_slope  = s_tdata[91:60];
	assign out_offset = s_tdata[115:92];
	assign sec_ok     = (sector[3:2] == 2'b00);

	// radii: zero for an invalid sector, the plane is masked anyway
	logic [13:0] r_inner;
	logic [13:0] r_middle;
	logic [13:0] r_outer;
	logic        ok_mid;
	logic        ok_out;

	assign r_inner  = sec_ok ? teta_pkg::radius(sector[1:0], teta_pkg::PLANE_INNER)  : 14'd0;
	assign r_middle = sec_ok ? teta_pkg::radius(sector[1:0], teta_pkg::PLANE_MIDDLE) : 14'd0;
	assign r_outer  = sec_ok ? teta_pkg::radius(sector[1:0], teta_pkg::PLANE_OUTER)  : 14'd0;
	assign ok_mid   = sec_ok && (mid_slope != 32'sd0);
	assign ok_out   = sec_ok && (out_slope != 32'sd0);

	logic [15:0] eta_i;
	logic [15:0] eta_m;
	logic [15:0] eta_o;
	logic        ok_i;
	logic        ok_m;
	logic        ok_o;

	// inner and middle planes both use the middle fit
	teta_plane u_inner (
		.clk    (clk),
		.en     (en),
		.r      (r_inner),
		.ok_in  (ok_mid),
		.slope  (mid_slope),
		.offset (mid_offset),
		.eta    (eta_i),
		.ok     (ok_i)
	);

	teta_plane u_middle (
		.clk    (clk),
		.en     (en),
		.r      (r_middle),
		.ok_in  (ok_mid),
		.slope  (mid_slope),
		.offset (mid_offset),
		.eta    (eta_m),
		.ok     (ok_m)
	);

	teta_plane u_outer (
		.clk    (clk),
		.en     (en),
		.r      (r_outer),
		.ok_in  (ok_out),
		.slope  (out_slope),
		.offset (out_offset),
		.eta    (eta_o),
		.ok     (ok_o)
	);

	// stage valid bits and the event marker travel beside the datapath
	logic [Lat-1:0] vld_q;
	logic [Lat-1:0] last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= {last_q[Lat-2:0], s_tlast};
		end
	end

	// output buffer, two entries, head in buf0_q
	teta_pkg::result_t res_c;
	teta_pkg::result_t buf0_q;
	teta_pkg::result_t buf1_q;
	logic              push;
	logic              pop;

	assign res_c = '{last: last_q[Lat-1], ok_o: ok_o, ok_m: ok_m, ok_i: ok_i,
		eta_o: eta_o, eta_m: eta_m, eta_i: eta_i};
	assign push  = en && vld_q[Lat-1];
	assign pop   = m_tready && (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					buf0_q <= res_c;
				end else begin
					buf1_q <= res_c;
				end
			end
			2'b01: begin
				buf0_q <= buf1_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					buf0_q <= res_c;
				end else begin
					buf0_q <= buf1_q;
					buf1_q <= res_c;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {buf0_q.eta_o, buf0_q.eta_m, buf0_q.eta_i};
	assign m_tuser  = {buf0_q.ok_o, buf0_q.ok_m, buf0_q.ok_i};
	assign m_tlast  = buf0_q.last;

endmodule

// ===== sim/tb_track_eta_at_rpc_planes_unit.sv =====
// ----------------------------------------------------------------------------
// tb_track_eta_at_rpc_planes_unit: stream test of track eta at trigger planes
// Drive muon candidates in random bursts, stall the result side at random and
// check every result against an integer model of the per-plane asinh.
// ----------------------------------------------------------------------------
module tb_track_eta_at_rpc_planes_unit;

	typedef struct packed {
		logic [23:0] out_offset;
		logic [31:0] out_slope;
		logic [23:0] mid_offset;
		logic [31:0] mid_slope;
		logic [3:0]  sector;
	} cand_t;

	typedef struct {
		cand_t c;
		logic  last;
	} cand_item_t;

	typedef struct {
		logic [15:0] eta_i, eta_m, eta_o;
		logic        ok_i, ok_m, ok_o, last;
	} eta_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// sector, mid_slope, mid_offset, out_slope, out_offset, zero fill (low first)
	logic [119:0] s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	// inner_eta, middle_eta, outer_eta (low first)
	logic [47:0]  m_tdata;
	// inner_ok, middle_ok, outer_ok (low first)
	logic [2:0]   m_tuser;
	logic         m_tlast;

	track_eta_at_rpc_planes_unit dut (.*);

	cand_item_t pending_cands[$];
	eta_res_t   expected_etas[$];
	int         n_errors = 0;
	int         n_sent = 0;
	int         n_checked = 0;
	int         n_sat = 0;
	bit         stim_done = 0;
	bit         in_fire = 0;

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// ---------------------------------------------------------------- predictor
	function automatic logic [13:0] plane_radius(input int sec, input int pl);
		int tbl[4][3] = '{'{6800, 7478, 9832}, '{7820, 8365, 10229},
			'{7740, 8100, 11000}, '{7850, 8400, 10400}};
		return 14'(tbl[sec][pl]);
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// |asinh(num/den)| in Q.12 before saturation
	function automatic longint unsigned asinh_q12(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q, rem, a, y, m, lg, prod;
		int p;
		q = num / den;
		rem = num % den;
		if (q >= 1491) return 32768;
		a = q;
		for (int i = 0; i < 20; i++) begin
			rem <<= 1;
			a <<= 1;
			if (rem >= den) begin
				rem -= den;
				a |= 1;
			end
		end
		y = a + root_floor(a * a + (64'd1 << 40));
		p = 20;
		while (p < 63 && (y >> (p + 1)) != 0) p++;
		m = (p <= 30) ? (y << (30 - p)) : (y >> (p - 30));
		lg = 64'(p - 20);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			lg <<= 1;
			if (m >= (64'd2 << 30)) begin
				lg |= 1;
				m >>= 1;
			end
		end
		prod = lg * 64'hB172_17F8;
		return (prod + (64'd1 << 35)) >> 36;
	endfunction

	function automatic logic [15:0] plane_eta(input logic [13:0] r,
			input logic signed [31:0] slope, input logic signed [23:0] offset,
			output logic ok);
		longint n, d;
		longint unsigned mag;
		bit neg;
		ok = 1'b0;
		if (slope == 0) return 16'd0;
		ok = 1'b1;
		n = 16 * longint'(r) - longint'(offset);
		if (n == 0) return 16'd0;
		d = longint'(slope) * longint'(r);
		neg = (n < 0) != (d < 0);
		mag = asinh_q12((n < 0 ? -n : n) * 4096, d < 0 ? -d : d);
		if (neg) begin
			if (mag > 32768) mag = 32768;
			return 16'(-longint'(mag));
		end
		if (mag > 32767) mag = 32767;
		return 16'(mag);
	endfunction

	function automatic eta_res_t predict_etas(input cand_item_t it);
		eta_res_t e;
		int sec;
		e = '{default: '0};
		e.last = it.last;
		sec = it.c.sector;
		if (sec < 4) begin
			e.eta_i = plane_eta(plane_radius(sec, 0), it.c.mid_slope, it.c.mid_offset, e.ok_i);
			e.eta_m = plane_eta(plane_radius(sec, 1), it.c.mid_slope, it.c.mid_offset, e.ok_m);
			e.eta_o = plane_eta(plane_radius(sec, 2), it.c.out_slope, it.c.out_offset, e.ok_o);
		end
		return e;
	endfunction

	// ---------------------------------------------------------------- driver
	// Sender runs in bursts; a gap count of zero means keep streaming.
	int burst_left = 0;
	int gap_left = 0;

	// remember whether the driven transfer was taken at the last rising edge
	always @(posedge clk) begin
		in_fire <= arst_n && s_tvalid && s_tready;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !in_fire) begin
				// hold the current transfer until it is taken
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_cands.size() > 0) begin
				cand_item_t it;
				it = pending_cands.pop_front();
				s_tdata <= {4'd0, it.c};
				s_tlast <= it.last;
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver stalls in phases: free running, light stalls, heavy stalls.
	int stall_mode = 0;
	always @(negedge clk) begin
		if ($urandom_range(0, 60) == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// ---------------------------------------------------------------- monitor
	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		n_errors++;
		$display("mismatch at result %0d: %s got %h expected %h", n_checked, what, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			cand_item_t it;
			it.c = s_tdata[115:0];
			it.last = s_tlast;
			expected_etas.insert(expected_etas.size(), predict_etas(it));
			n_sent++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_etas.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[15:0], 16'd0);
			end else begin
				eta_res_t e;
				e = expected_etas.pop_front();
				if (m_tdata[15:0] !== e.eta_i) report_mismatch("inner_eta", m_tdata[15:0], e.eta_i);
				if (m_tdata[31:16] !== e.eta_m)
					report_mismatch("middle_eta", m_tdata[31:16], e.eta_m);
				if (m_tdata[47:32] !== e.eta_o)
					report_mismatch("outer_eta", m_tdata[47:32], e.eta_o);
				if (m_tuser[0] !== e.ok_i)
					report_mismatch("inner_ok", 16'(m_tuser[0]), 16'(e.ok_i));
				if (m_tuser[1] !== e.ok_m)
					report_mismatch("middle_ok", 16'(m_tuser[1]), 16'(e.ok_m));
				if (m_tuser[2] !== e.ok_o)
					report_mismatch("outer_ok", 16'(m_tuser[2]), 16'(e.ok_o));
				if (m_tlast !== e.last)
					report_mismatch("event_end", 16'(m_tlast), 16'(e.last));
				if (e.eta_m == teta_pkg::ETA_MAX_POS || e.eta_m == teta_pkg::ETA_MIN_NEG) n_sat++;
				n_checked++;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	function automatic logic [31:0] rand_slope();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 131072)) - 65536);
			2: return 32'($signed($urandom_range(0, 8)) - 4);
			3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	function automatic logic [23:0] rand_offset(input int sec, input int pl);
		case ($urandom_range(0, 4))
			0: return 24'($urandom());
			1: return 24'(16 * plane_radius(sec & 3, pl));
			2: return $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
			default: return 24'($signed($urandom_range(0, 200000)) - 100000);
		endcase
	endfunction

	task automatic add_cand(input logic [3:0] sec, input logic [31:0] ms,
			input logic [23:0] mo, input logic [31:0] os, input logic [23:0] oo,
			input logic last);
		cand_item_t it;
		it.c = '{out_offset: oo, out_slope: os, mid_offset: mo, mid_slope: ms, sector: sec};
		it.last = last;
		pending_cands.insert(pending_cands.size(), it);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: every sector kind, invalid sectors, zero slopes,
		// offset at 16*R, field extremes and saturation both ways
		for (int s = 0; s < 4; s++)
			add_cand(4'(s), 32'h0001_0000, 24'd0, 32'hFFFF_0000, 24'd100, s == 3);
		add_cand(4'd4, 32'h0001_0000, 24'd0, 32'h0001_0000, 24'd0, 1'b0);
		add_cand(4'd15, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1);
		add_cand(4'd0, 32'd0, 24'd0, 32'h0002_0000, 24'd0, 1'b0);
		add_cand(4'd1, 32'h0001_0000, 24'd0, 32'd0, 24'd0, 1'b1);
		add_cand(4'd0, 32'h0001_0000, 24'(16 * 6800), 32'h0001_0000, 24'(16 * 9832), 1'b0);
		add_cand(4'd2, 32'h0000_8000, 24'(16 * 8100), 32'h0001_0000, 24'(16 * 11000), 1'b0);
		add_cand(4'd3, 32'h7FFF_FFFF, 24'h7F_FFFF, 32'h8000_0000, 24'h80_0000, 1'b1);
		add_cand(4'd0, 32'd1, 24'd0, 32'hFFFF_FFFF, 24'd0, 1'b0);
		add_cand(4'd1, 32'd1, 24'h80_0000, 32'd1, 24'h7F_FFFF, 1'b0);
		add_cand(4'd2, 32'h8000_0000, 24'h7F_FFFF, 32'h7FFF_FFFF, 24'h80_0000, 1'b1);
		add_cand(4'd3, 32'd100, 24'd5, 32'hFFFF_FF00, 24'd5, 1'b0);
		add_cand(4'd0, 32'h00A0_0000, 24'd0, 32'hFF60_0000, 24'd0, 1'b1);

		for (int i = 0; i < 450; i++) begin
			logic [3:0] sec;
			sec = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(4, 15)) : 4'($urandom_range(0, 3));
			add_cand(sec, rand_slope(), rand_offset(int'(sec), 1), rand_slope(),
				rand_offset(int'(sec), 2), $urandom_range(0, 3) == 0);
		end
		while (pending_cands.size() != 0 || s_tvalid) @(posedge clk);
		stim_done = 1;
	end

	initial begin
		wait (stim_done && expected_etas.size() == 0);
		repeat (teta_pkg::PLANE_LAT + 20) @(posedge clk);
		$display("sent %0d candidates, checked %0d results, %0d saturated middle etas",
			n_sent, n_checked, n_sat);
		if (n_errors == 0 && expected_etas.size() == 0) begin
			$display("PASS track_eta_at_rpc_planes_unit");
		end else begin
			$display("FAIL track_eta_at_rpc_planes_unit");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", expected_etas.size());
		$display("FAIL track_eta_at_rpc_planes_unit");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/teta_pkg.sv
hdl/teta_div_cell.sv
hdl/teta_sqrt_cell.sv
hdl/teta_log_cell.sv
hdl/teta_plane.sv
hdl/track_eta_at_rpc_planes_unit.sv
sim/tb_track_eta_at_rpc_planes_unit.sv
